@@ hdl/lgp_pkg.sv @@
// lgp_pkg: shared types and constants for the local grid projection block
// fixed-point formats, payload structs, register indexes and cosine series terms
// no dependencies; used by lgp_cos_rom and local_grid_projection_top
`default_nettype none

package lgp_pkg;

  // angles are degrees with this many fraction bits
  localparam int FRAC_BITS = 20;
  localparam int ONE_DEG   = 1 << FRAC_BITS;
  localparam int GRID_SIZE = 720;

  // field widths
  localparam int POS_X_W  = 31;
  localparam int POS_Y_W  = 28;
  localparam int CENTER_X_W = 29;
  localparam int CENTER_Y_W = 28;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;

  // cosine table format, q1.16
  localparam int COS_FRAC = 16;
  localparam int COS_W    = COS_FRAC + 1;

  // pi/2 in q30 and the taylor divisors (2n-1)*2n for n = 1..10
  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic [63:0] COS_TERM_DIV [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 29;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y = 1'd1;

  // reset value of center_y: 90 degrees
  localparam logic [CENTER_Y_W-1:0] CENTER_Y_RESET = CENTER_Y_W'(90 * ONE_DEG);

  typedef struct packed {
    logic signed [POS_X_W-1:0] position_x;
    logic [POS_Y_W-1:0]        position_y;
  } pos_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic             in_map;
  } grid_t;

endpackage

`default_nettype wire

@@ hdl/lgp_cos_rom.sv @@
// lgp_cos_rom: quarter-wave cosine table in q1.16 with a registered read
// entries are built at elaboration from an integer taylor series
// depends on lgp_pkg
`default_nettype none

module lgp_cos_rom #(
  parameter int COS_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [$clog2(COS_DEPTH)-1:0]     addr,
  output logic      [lgp_pkg::COS_W-1:0]        data
);

  // cos(k * 90deg / COS_DEPTH): angle in q30, ten terms, truncating products
  function automatic logic [lgp_pkg::COS_W-1:0] cos_entry(input int unsigned k);
    logic [63:0]        th;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rounded;
    th   = (64'(k) * lgp_pkg::HALFPI_Q30) / 64'(COS_DEPTH);
    x2   = (th * th) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / lgp_pkg::COS_TERM_DIV[n-1];
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    rounded = (64'(sum) + (64'd1 << 13)) >> 14;
    return rounded[lgp_pkg::COS_W-1:0];
  endfunction

  logic [lgp_pkg::COS_W-1:0] rom [COS_DEPTH];

  for (genvar k = 0; k < COS_DEPTH; k++) begin : g_entry
    localparam logic [lgp_pkg::COS_W-1:0] ENTRY = cos_entry(k);
    assign rom[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/local_grid_projection_top.sv @@
// local_grid_projection_top: projects a position onto the row and column of a
// square local grid around a configured center, one position per clock while pos_stall is low
// depends on lgp_pkg and lgp_cos_rom
`default_nettype none

//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ------------------------------------
//  pos      in         pos_valid / pos_stall  lgp_pkg::pos_t  (position_x, position_y)
//  grid     out        grid_valid / grid_stall lgp_pkg::grid_t (row, column, in_map)
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data (center_x, center_y)
//
// six register stages: input, offsets + row, cosine index, cosine table read,
// cosine scaling multiply, column + result register; each result moves through
// them in that order, and one beat can enter every clock while pos_stall is low
// each stage has its own valid bit and loads when it is empty or its successor
// moves, so empty stages keep filling while a result waits on grid_stall
// rst clears the valid bits and sets center_x to 0 and center_y to 90 degrees
// cfg_ready is always high; a center register is written whenever cfg_valid is high

module local_grid_projection_top #(
  parameter int COSINE_TABLE_DEPTH = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               pos_valid,
  output logic                                    pos_stall,
  input  wire lgp_pkg::pos_t                      pos,
  output logic                                    grid_valid,
  input  wire logic                               grid_stall,
  output lgp_pkg::grid_t                          grid,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lgp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lgp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int F  = lgp_pkg::FRAC_BITS;
  localparam int IW = $clog2(COSINE_TABLE_DEPTH);
  // latitude scaled by the table depth, before dropping fraction bits
  localparam int LD_W = lgp_pkg::POS_Y_W + $clog2(COSINE_TABLE_DEPTH + 1);
  // table position before division by 90, latitude stays below 256 degrees
  localparam int MW = $clog2(256 * COSINE_TABLE_DEPTH + 46);
  // exact divide by 90 via reciprocal, error term stays below one lsb
  localparam int DIV_SH = MW + 7;
  localparam logic [DIV_SH:0] DIV90_RECIP = (DIV_SH+1)'(((64'd1 << DIV_SH) + 64'd89) / 64'd90);
  localparam int DX_W = lgp_pkg::POS_X_W;
  localparam int S_W  = DX_W + lgp_pkg::COS_W;
  localparam int COL_SHIFT = F + lgp_pkg::COS_FRAC + 1;

  localparam logic signed [lgp_pkg::POS_Y_W:0] DY_HALF = (lgp_pkg::POS_Y_W+1)'(lgp_pkg::ONE_DEG / 2);
  localparam logic signed [lgp_pkg::POS_Y_W:0] DEG90 = (lgp_pkg::POS_Y_W+1)'(90 * lgp_pkg::ONE_DEG);
  localparam logic signed [31:0] TURN   = 32'(360 * lgp_pkg::ONE_DEG);
  localparam logic signed [31:0] DEG180 = 32'(180 * lgp_pkg::ONE_DEG);
  localparam logic signed [31:0] ROW_SCALE = 32'(2 * lgp_pkg::GRID_SIZE);
  localparam logic signed [31:0] ROW_BIAS  = 32'((lgp_pkg::GRID_SIZE + 1) * lgp_pkg::ONE_DEG);
  localparam logic signed [S_W-1:0] S_HALF = S_W'(1) <<< (F - 1 + lgp_pkg::COS_FRAC);
  localparam logic signed [S_W-1:0] COL_SCALE = S_W'(2 * lgp_pkg::GRID_SIZE);
  localparam logic signed [S_W-1:0] COL_BIAS =
    S_W'(lgp_pkg::GRID_SIZE + 1) <<< (F + lgp_pkg::COS_FRAC);
  localparam logic [lgp_pkg::ROW_W:0] GRID_LIMIT = (lgp_pkg::ROW_W+1)'(lgp_pkg::GRID_SIZE);

  // configuration registers
  logic [lgp_pkg::CENTER_X_W-1:0] center_x;
  logic [lgp_pkg::CENTER_Y_W-1:0] center_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= lgp_pkg::CENTER_Y_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lgp_pkg::CFG_CENTER_X: center_x <= cfg_data[lgp_pkg::CENTER_X_W-1:0];
        lgp_pkg::CFG_CENTER_Y: center_y <= cfg_data[lgp_pkg::CENTER_Y_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and the move chain, back to front
  logic [4:0] stage_valid;
  logic [5:0] adv;

  assign adv[5] = !grid_valid || !grid_stall;
  for (genvar i = 0; i < 5; i++) begin : g_adv
    assign adv[i] = !stage_valid[i] || adv[i+1];
  end
  assign pos_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      grid_valid  <= 1'b0;
    end else begin
      if (adv[0]) begin
        stage_valid[0] <= pos_valid;
      end
      for (int i = 1; i < 5; i++) begin
        if (adv[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
      if (adv[5]) begin
        grid_valid <= stage_valid[4];
      end
    end
  end

  // stage 0: input register
  lgp_pkg::pos_t pos0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pos0 <= pos;
    end
  end

  // stage 1: row, wrapped longitude offset, cosine table position
  logic signed [lgp_pkg::POS_Y_W:0] dy;
  logic                             dy_ok;
  logic signed [31:0]               row_t;
  logic [lgp_pkg::ROW_W:0]          row_w;
  logic signed [31:0]               px_e;
  logic signed [31:0]               pw;
  logic signed [31:0]               dx0;
  logic signed [31:0]               dx_u;
  logic signed [lgp_pkg::POS_Y_W:0] lat_d;
  logic [lgp_pkg::POS_Y_W-1:0]      lat;
  logic [LD_W-1:0]                  lat_scaled;

  logic                   row_ok1;
  logic [lgp_pkg::ROW_W-1:0] row1;
  logic signed [DX_W-1:0] dx1;
  logic [MW-1:0]          m1;

  always_comb begin
    dy    = $signed({1'b0, pos0.position_y}) - $signed({1'b0, center_y});
    dy_ok = (dy < DY_HALF) && (dy > -DY_HALF);
    row_t = 32'(dy) * ROW_SCALE + ROW_BIAS;
    row_w = row_t[F+1 +: lgp_pkg::ROW_W+1];

    // one turn of correction, then unwrap across the antimeridian
    px_e = 32'(pos0.position_x);
    if (px_e < 0) begin
      pw = px_e + TURN;
    end else if (px_e >= TURN) begin
      pw = px_e - TURN;
    end else begin
      pw = px_e;
    end
    dx0 = pw - $signed({{(32-lgp_pkg::CENTER_X_W){1'b0}}, center_x});
    if (dx0 > DEG180) begin
      dx_u = dx0 - TURN;
    end else if (dx0 < -DEG180) begin
      dx_u = dx0 + TURN;
    end else begin
      dx_u = dx0;
    end

    // distance from the equator, scaled to table steps of 90/depth degrees
    lat_d = $signed({1'b0, pos0.position_y}) - DEG90;
    lat   = (lat_d < 0) ? lgp_pkg::POS_Y_W'(-lat_d) : lgp_pkg::POS_Y_W'(lat_d);
    lat_scaled = LD_W'(lat) * LD_W'(COSINE_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      row_ok1 <= dy_ok && (row_w < GRID_LIMIT);
      row1    <= row_w[lgp_pkg::ROW_W-1:0];
      dx1     <= dx_u[DX_W-1:0];
      // adding 45 before the divide by 90 rounds to nearest
      m1      <= MW'(lat_scaled >> F) + MW'(45);
    end
  end

  // stage 2: divide by 90, clamp to the last entry
  logic [MW+DIV_SH:0] q_prod;
  logic [MW-1:0]      q;
  logic [IW-1:0]      idx;

  logic                      row_ok2;
  logic [lgp_pkg::ROW_W-1:0] row2;
  logic signed [DX_W-1:0]    dx2;
  logic [IW-1:0]             idx2;

  always_comb begin
    q_prod = (MW+DIV_SH+1)'(m1) * (MW+DIV_SH+1)'(DIV90_RECIP);
    q      = q_prod[DIV_SH +: MW];
    if (q >= MW'(COSINE_TABLE_DEPTH)) begin
      idx = IW'(COSINE_TABLE_DEPTH - 1);
    end else begin
      idx = q[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      row_ok2 <= row_ok1;
      row2    <= row1;
      dx2     <= dx1;
      idx2    <= idx;
    end
  end

  // stage 3: cosine table read
  logic [lgp_pkg::COS_W-1:0] cos3;
  logic                      row_ok3;
  logic [lgp_pkg::ROW_W-1:0] row3;
  logic signed [DX_W-1:0]    dx3;

  lgp_cos_rom #(
    .COS_DEPTH(COSINE_TABLE_DEPTH)
  ) u_cos_rom (
    .clk (clk),
    .en  (adv[3]),
    .addr(idx2),
    .data(cos3)
  );

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      row_ok3 <= row_ok2;
      row3    <= row2;
      dx3     <= dx2;
    end
  end

  // stage 4: scale the longitude offset by cos(latitude)
  logic signed [S_W-1:0]     s_next;
  logic signed [S_W-1:0]     s4;
  logic                      row_ok4;
  logic [lgp_pkg::ROW_W-1:0] row4;

  assign s_next = dx3 * $signed({1'b0, cos3});

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4      <= s_next;
      row_ok4 <= row_ok3;
      row4    <= row3;
    end
  end

  // stage 5: column, bounds, result register
  logic signed [S_W-1:0]     col_t;
  logic [lgp_pkg::COL_W:0]   col_w;
  logic                      in_map;
  lgp_pkg::grid_t            grid_next;

  always_comb begin
    col_t  = s4 * COL_SCALE + COL_BIAS;
    col_w  = col_t[COL_SHIFT +: lgp_pkg::COL_W+1];
    in_map = row_ok4 && (s4 < S_HALF) && (s4 > -S_HALF)
             && (col_w < (lgp_pkg::COL_W+1)'(lgp_pkg::GRID_SIZE));
    // off map: every field reads zero
    grid_next.row_index    = in_map ? row4 : '0;
    grid_next.column_index = in_map ? col_w[lgp_pkg::COL_W-1:0] : '0;
    grid_next.in_map       = in_map;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      grid <= grid_next;
    end
  end

endmodule

`default_nettype wire
